FILE: rtl/bbrc_pkg.sv
// Shared types and constants for the bit balance and run check block.
// No dependencies; every other file in rtl/ imports this package.
package bbrc_pkg;

  localparam int unsigned BLOCK_BYTES = 32;
  localparam int unsigned IDX_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CNT_W       = 9;   // ones count and run lengths
  localparam int unsigned RSLACK_W    = 9;
  localparam int unsigned BSLACK_W    = 8;
  localparam int unsigned CFG_W       = 9;   // widest register
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned LIM_W       = 11;  // signed limits and compares

  localparam int RUN_BASE  = 29;
  localparam int HALF_BITS = 128;
  localparam int OVER_BAL  = 167 - 128;

  localparam logic [CFG_IDX_W-1:0] CFG_RUN_SLACK     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_SLACK = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_PASS      = 3'd0,
    VERDICT_TOO_MANY  = 3'd1,
    VERDICT_TOO_FEW   = 3'd2,
    VERDICT_ZERO_RUN  = 3'd3,
    VERDICT_ONE_RUN   = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [CNT_W-1:0] ones;
    logic [CNT_W-1:0] zero_run;
    logic [CNT_W-1:0] one_run;
  } block_stats_t;

endpackage

FILE: rtl/bbrc_if.sv
// Valid/ready channel interfaces for byte input and verdict output.
// Depends on bbrc_pkg.
interface bbrc_in_if import bbrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, output byte_value, input ready);
  modport sink   (input valid, input byte_value, output ready);
endinterface

interface bbrc_out_if import bbrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       verdict;
  logic [CNT_W-1:0] ones_count;
  logic [CNT_W-1:0] longest_zero_run;
  logic [CNT_W-1:0] longest_one_run;

  modport source (output valid, output verdict, output ones_count,
                  output longest_zero_run, output longest_one_run, input ready);
  modport sink   (input valid, input verdict, input ones_count,
                  input longest_zero_run, input longest_one_run, output ready);
endinterface

FILE: rtl/bbrc_scan.sv
// Block state and per-byte scan: ones count and run tracking, LSB first.
// Depends on bbrc_pkg.
module bbrc_scan import bbrc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [BYTE_W-1:0] byte_i,
  output logic              last_o,
  output block_stats_t      stats_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] ones_q, ones_d;
  logic [CNT_W-1:0] run_q, run_d;
  logic             bit_q, bit_d;
  logic [CNT_W-1:0] bz_q, bz_d;
  logic [CNT_W-1:0] bo_q, bo_d;

  assign last_o = (idx_q == IDX_W'(BLOCK_BYTES - 1));

  // Eight dependent bit steps on narrow values.
  always_comb begin : p_scan
    logic [CNT_W-1:0] ones, run, bz, bo;
    logic             cur;
    ones = ones_q;
    run  = run_q;
    cur  = bit_q;
    bz   = bz_q;
    bo   = bo_q;
    for (int b = 0; b < BYTE_W; b++) begin
      ones = ones + CNT_W'(byte_i[b]);
      if (run != '0 && byte_i[b] == cur) begin
        run = run + CNT_W'(1);
      end else begin
        if (run != '0) begin
          if (cur) begin
            if (run > bo) bo = run;
          end else begin
            if (run > bz) bz = run;
          end
        end
        cur = byte_i[b];
        run = CNT_W'(1);
      end
    end
    ones_d = ones;
    run_d  = run;
    bit_d  = cur;
    bz_d   = bz;
    bo_d   = bo;
    // close the open run for the block summary
    stats_o.ones     = ones;
    stats_o.zero_run = (!cur && run > bz) ? run : bz;
    stats_o.one_run  = (cur && run > bo) ? run : bo;
  end

  assign idx_d = idx_q + IDX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      ones_q <= '0;
      run_q  <= '0;
      bit_q  <= 1'b0;
      bz_q   <= '0;
      bo_q   <= '0;
    end else if (step_i) begin
      if (last_o) begin
        idx_q  <= '0;
        ones_q <= '0;
        run_q  <= '0;
        bit_q  <= 1'b0;
        bz_q   <= '0;
        bo_q   <= '0;
      end else begin
        idx_q  <= idx_d;
        ones_q <= ones_d;
        run_q  <= run_d;
        bit_q  <= bit_d;
        bz_q   <= bz_d;
        bo_q   <= bo_d;
      end
    end
  end

endmodule

FILE: rtl/bit_balance_and_run_check.sv
// Randomness check over blocks of 32 bytes: counts the one bits and the longest
// zero and one runs (LSB first, carried across bytes), then gives one verdict per
// block. One byte is taken every cycle while the input does not stall; a byte
// waits in the input register, and the verdict is registered when the last byte
// of a block leaves it. Input stalls only when a finished block meets a verdict
// that the sink has not yet taken. Depends on bbrc_pkg, bbrc_if, bbrc_scan.
module bit_balance_and_run_check import bbrc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  bbrc_in_if.sink              in_i,
  bbrc_out_if.source           out_o
);

  logic signed [RSLACK_W-1:0] run_slack_q;
  logic signed [BSLACK_W-1:0] bal_slack_q;

  logic              in_vld_q;
  logic [BYTE_W-1:0] in_byte_q;

  logic              res_vld_q;
  verdict_e          verdict_q, verdict_d;
  block_stats_t      stats_q, stats;

  logic last, out_free, fire;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_slack_q <= '0;
      bal_slack_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RUN_SLACK:     run_slack_q <= cfg_data_i[RSLACK_W-1:0];
        CFG_BALANCE_SLACK: bal_slack_q <= cfg_data_i[BSLACK_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !res_vld_q || out_o.ready;
  assign fire     = in_vld_q && (!last || out_free);
  assign in_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.byte_value;
    end
  end

  bbrc_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (fire),
    .byte_i  (in_byte_q),
    .last_o  (last),
    .stats_o (stats)
  );

  // Limits as signed values; a negative run limit fails every run, while a negative lower ones limit fails no count.
  logic signed [LIM_W-1:0] run_lim, hi_lim, lo_lim, ones_s, bz_s, bo_s;
  assign run_lim = LIM_W'(RUN_BASE) + LIM_W'(run_slack_q);
  assign hi_lim  = LIM_W'(HALF_BITS + OVER_BAL) + LIM_W'(bal_slack_q);
  assign lo_lim  = LIM_W'(HALF_BITS - OVER_BAL) - LIM_W'(bal_slack_q);
  assign ones_s  = signed'(LIM_W'(stats.ones));
  assign bz_s    = signed'(LIM_W'(stats.zero_run));
  assign bo_s    = signed'(LIM_W'(stats.one_run));

  always_comb begin
    if (ones_s > hi_lim) begin
      verdict_d = VERDICT_TOO_MANY;
    end else if (ones_s < lo_lim) begin
      verdict_d = VERDICT_TOO_FEW;
    end else if (bz_s > run_lim) begin
      verdict_d = VERDICT_ZERO_RUN;
    end else if (bo_s > run_lim) begin
      verdict_d = VERDICT_ONE_RUN;
    end else begin
      verdict_d = VERDICT_PASS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (fire && last) begin
      res_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && last) begin
      verdict_q <= verdict_d;
      stats_q   <= stats;
    end
  end

  assign out_o.valid            = res_vld_q;
  assign out_o.verdict          = verdict_q;
  assign out_o.ones_count       = stats_q.ones;
  assign out_o.longest_zero_run = stats_q.zero_run;
  assign out_o.longest_one_run  = stats_q.one_run;

  // A block of 256 bits holds at most 256 ones.
  a_ones_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> stats_q.ones <= CNT_W'(BLOCK_BYTES * BYTE_W))
    else $error("ones count out of range");

  // A block with no ones has no one run, and the reverse.
  a_ones_vs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> ((stats_q.ones == '0) == (stats_q.one_run == '0)))
    else $error("ones count disagrees with longest one run");

  // Every finished block holds at least one run.
  a_some_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> (stats_q.zero_run != '0 || stats_q.one_run != '0))
    else $error("finished block without any run");

  // A byte held in the input register is not overwritten while it waits.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !fire) |=> (in_vld_q && $stable(in_byte_q)))
    else $error("waiting input byte lost");

endmodule

FILE: dv/bbrc_checker.sv
// Scoreboard for bit_balance_and_run_check: watches the byte and verdict channels
// and the register port, predicts each block verdict and compares it field by field.
// Depends on bbrc_pkg and the channel interfaces in bbrc_if.
module bbrc_checker import bbrc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  bbrc_in_if                   in_mon,
  bbrc_out_if                  out_mon,
  output int unsigned          errors_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    verdict_e     verdict;
    block_stats_t stats;
  } block_result_t;

  logic [IDX_W-1:0] byte_pos     = '0;
  logic [CNT_W-1:0] ones_acc     = '0;
  logic [CNT_W-1:0] open_run     = '0;
  logic             open_bit     = 1'b0;
  logic [CNT_W-1:0] top_zero_run = '0;
  logic [CNT_W-1:0] top_one_run  = '0;
  int               run_slack_q     = 0;
  int               balance_slack_q = 0;
  int unsigned      mismatches      = 0;
  block_result_t    due_verdicts[$];

  task automatic clear_block_stats();
    byte_pos     = '0;
    ones_acc     = '0;
    open_run     = '0;
    open_bit     = 1'b0;
    top_zero_run = '0;
    top_one_run  = '0;
  endtask

  task automatic commit_run();
    if (open_run != '0) begin
      if (open_bit) begin
        if (open_run > top_one_run) top_one_run = open_run;
      end else begin
        if (open_run > top_zero_run) top_zero_run = open_run;
      end
    end
  endtask

  task automatic scan_byte(input logic [BYTE_W-1:0] value);
    block_result_t res;
    int            run_limit;
    int            hi_limit;
    int            lo_limit;
    for (int k = 0; k < BYTE_W; k++) begin
      ones_acc = ones_acc + CNT_W'(value[k]);
      if (open_run != '0 && value[k] == open_bit) begin
        open_run = open_run + CNT_W'(1);
      end else begin
        commit_run();
        open_bit = value[k];
        open_run = CNT_W'(1);
      end
    end
    if (byte_pos != IDX_W'(BLOCK_BYTES - 1)) begin
      byte_pos = byte_pos + IDX_W'(1);
      return;
    end
    commit_run();
    run_limit = RUN_BASE + run_slack_q;
    hi_limit  = HALF_BITS + OVER_BAL + balance_slack_q;
    lo_limit  = HALF_BITS - OVER_BAL - balance_slack_q;
    if (int'(ones_acc) > hi_limit)          res.verdict = VERDICT_TOO_MANY;
    else if (int'(ones_acc) < lo_limit)     res.verdict = VERDICT_TOO_FEW;
    else if (int'(top_zero_run) > run_limit) res.verdict = VERDICT_ZERO_RUN;
    else if (int'(top_one_run) > run_limit)  res.verdict = VERDICT_ONE_RUN;
    else                                     res.verdict = VERDICT_PASS;
    res.stats.ones     = ones_acc;
    res.stats.zero_run = top_zero_run;
    res.stats.one_run  = top_one_run;
    due_verdicts.push_back(res);
    clear_block_stats();
  endtask

  task automatic flag(input string what, input int unsigned want, input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch: %s expected %0d actual %0d", what, want, got);
  endtask

  task automatic check_verdict();
    block_result_t want;
    if (due_verdicts.size() == 0) begin
      flag("unexpected verdict beat, verdict", 0, out_mon.verdict);
      return;
    end
    want = due_verdicts.pop_front();
    if (out_mon.verdict != want.verdict)
      flag("verdict", want.verdict, out_mon.verdict);
    if (out_mon.ones_count != want.stats.ones)
      flag("ones_count", want.stats.ones, out_mon.ones_count);
    if (out_mon.longest_zero_run != want.stats.zero_run)
      flag("longest_zero_run", want.stats.zero_run, out_mon.longest_zero_run);
    if (out_mon.longest_one_run != want.stats.one_run)
      flag("longest_one_run", want.stats.one_run, out_mon.longest_one_run);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_block_stats();
      run_slack_q     = 0;
      balance_slack_q = 0;
      due_verdicts.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // Retire the verdict first: it always belongs to an older block.
      if (out_mon.valid && out_mon.ready) check_verdict();
      if (in_mon.valid && in_mon.ready) scan_byte(in_mon.byte_value);
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_RUN_SLACK)
          run_slack_q = $signed(cfg_data_i[RSLACK_W-1:0]);
        else if (cfg_idx_i == CFG_BALANCE_SLACK)
          balance_slack_q = $signed(cfg_data_i[BSLACK_W-1:0]);
      end
      errors_o  <= mismatches;
      pending_o <= due_verdicts.size();
    end
  end

endmodule

FILE: dv/testbench.sv
// Top of the bit_balance_and_run_check bench: clock, reset, byte and verdict traffic,
// register phases and the final verdict. Checking lives in bbrc_checker.
// Depends on bbrc_pkg, bbrc_if, the block itself and bbrc_checker.
module testbench;
  import bbrc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned BLOCK_BITS  = BLOCK_BYTES * BYTE_W;

  logic                 clk    = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  logic                 rx_hold = 1'b0;
  int unsigned          cycle_count = 0;
  int unsigned          mismatch_total;
  int unsigned          verdicts_due;

  bbrc_in_if  in_ch ();
  bbrc_out_if out_ch ();

  bit_balance_and_run_check dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  bbrc_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .errors_o   (mismatch_total),
    .pending_o  (verdicts_due)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [BLOCK_BITS-1:0] random_block();
    logic [BLOCK_BITS-1:0] bits;
    int unsigned           density;
    int unsigned           start;
    int unsigned           len;
    logic                  fill;
    for (int k = 0; k < BLOCK_BITS / 32; k++) bits[32*k +: 32] = $urandom();
    case ($urandom_range(0, 3))
      2: begin
        // Skew the ones density, mostly near the balance thresholds.
        density = $urandom_range(0, 1) ? $urandom_range(0, 100) : $urandom_range(28, 72);
        for (int i = 0; i < BLOCK_BITS; i++) bits[i] = ($urandom_range(0, 99) < density);
      end
      3: begin
        // Plant a long run, possibly crossing byte boundaries.
        start = $urandom_range(0, BLOCK_BITS - 1);
        len   = $urandom_range(16, 160);
        fill  = $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
          if (start + i < BLOCK_BITS) bits[start + i] = fill;
      end
      default: ;
    endcase
    return bits;
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] value, input bit burst);
    int unsigned gap;
    gap = (burst || rx_hold) ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.byte_value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_block(input logic [BLOCK_BITS-1:0] bits);
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < BLOCK_BYTES; k++) push_byte(bits[BYTE_W*k +: BYTE_W], burst);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (verdicts_due != 0);
  endtask

  task automatic write_slacks(input logic [RSLACK_W-1:0] run_slack,
                              input logic [BSLACK_W-1:0] balance_slack);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_RUN_SLACK;
    cfg_data <= CFG_W'(run_slack);
    @(posedge clk);
    cfg_idx  <= CFG_BALANCE_SLACK;
    cfg_data <= {1'($urandom_range(0, 1)), balance_slack};
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Verdict sink: random stalls, plus one long hold-off to back up the block.
  initial begin
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (taken == 8) begin
        rx_hold      <= 1'b1;
        out_ch.ready <= 1'b0;
        repeat (800) @(posedge clk);
        rx_hold      <= 1'b0;
      end else begin
        stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  initial begin
    logic [RSLACK_W-1:0] run_slack;
    logic [BSLACK_W-1:0] balance_slack;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_RUN_SLACK;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.byte_value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed blocks at reset settings: all zeros, all ones, alternating bits; then two random blocks.
    send_block('0);
    send_block('1);
    send_block({BLOCK_BITS/8{8'h55}});
    repeat (2) send_block(random_block());

    for (int phase = 1; phase <= 7; phase++) begin
      wait_idle();
      repeat (4) @(posedge clk);
      case (phase)
        1: begin run_slack = -9'sd29;  balance_slack = -8'sd39;  end
        2: begin run_slack = 9'sd226;  balance_slack = 8'sd88;   end
        3: begin run_slack = 9'h100;   balance_slack = 8'h80;    end
        4: begin run_slack = 9'h0ff;   balance_slack = 8'h7f;    end
        default: begin
          run_slack     = RSLACK_W'($urandom_range(0, 255) - 29);
          balance_slack = BSLACK_W'($urandom_range(0, 127) - 39);
        end
      endcase
      write_slacks(run_slack, balance_slack);
      repeat (6) send_block(random_block());
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
